[src/lwsp_pkg.sv]
// shared constants, request codes and controller/datapath command types
// for the load weighted server picker; no dependencies
package lwsp_pkg;

  localparam int unsigned NUM_SERVERS = 16;
  localparam int unsigned SCALE       = 10000;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned LOAD_W = 16;
  localparam int unsigned W_W    = 14;
  localparam int unsigned CNT_W  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int unsigned SUM_W  = $clog2(NUM_SERVERS * SCALE + 1);
  localparam int unsigned PROD_W = LOAD_W + W_W;
  localparam int unsigned DEN_W  = (SUM_W > LOAD_W) ? SUM_W : LOAD_W;
  localparam int unsigned DCNT_W = $clog2(PROD_W);

  // reciprocal of SCALE, exact floor quotient for every LOAD_W-bit value
  localparam int unsigned       MOD_SH  = LOAD_W + $clog2(SCALE);
  localparam int unsigned       MOD_M_W = LOAD_W + 2;
  localparam logic [MOD_M_W-1:0] MOD_M  = MOD_M_W'((64'd1 << MOD_SH) / SCALE + 1);

  localparam logic [LOAD_W-1:0] MAX_PEOPLE_RST = LOAD_W'(1000);

  typedef enum logic [1:0] {
    REQ_UPDATE    = 2'd0,
    REQ_RECOMPUTE = 2'd1,
    REQ_PICK      = 2'd2
  } lwsp_req_t;

  typedef enum logic {
    MUL_HEADROOM,
    MUL_WEIGHT
  } lwsp_mul_sel_t;

  typedef enum logic {
    DVS_MAX,
    DVS_SUM
  } lwsp_dvs_t;

  typedef struct packed {
    logic          capture;
    logic          write_entry;
    logic          clear_walk;
    logic          cnt_inc;
    logic          cnt_clr;
    logic          mul;
    lwsp_mul_sel_t mul_sel;
    logic          div_start;
    lwsp_dvs_t     div_den;
    logic          div_step;
    logic          store_raw;
    logic          store_norm;
    logic          mod_quo;
    logic          save_rem;
    logic          pick_test;
    logic          out_load;
  } lwsp_cmd_t;

  typedef struct packed {
    lwsp_req_t req;
    logic      raw_zero;
    logic      sum_zero;
    logic      cnt_last;
    logic      div_last;
    logic      match;
    logic      out_free;
  } lwsp_status_t;

endpackage

[src/lwsp_div.sv]
// restoring divider, one quotient bit per step, divisor latched at start
// depends on lwsp_pkg
module lwsp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          step,
  input  logic [lwsp_pkg::PROD_W-1:0]   dividend,
  input  logic [lwsp_pkg::DEN_W-1:0]    divisor,
  output logic [lwsp_pkg::PROD_W-1:0]   quotient,
  output logic                          last
);
  import lwsp_pkg::*;

  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [PROD_W-1:0] quo;
  logic [DCNT_W-1:0] cnt;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign shifted   = {rem, quo[PROD_W-1]};
  assign ge        = shifted >= {1'b0, den};
  assign diff      = shifted - {1'b0, den};
  assign last      = cnt == DCNT_W'(PROD_W - 1);
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[PROD_W-2:0], ge};
    end
  end

endmodule

[src/lwsp_datapath.sv]
// server table, weight and range registers, multiplier, divider and result register
// depends on lwsp_pkg and lwsp_div
module lwsp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lwsp_pkg::LOAD_W-1:0]   cfg_wdata,
  input  logic [1:0]                    req_type,
  input  logic [lwsp_pkg::IDX_W-1:0]    server_index,
  input  logic [lwsp_pkg::LOAD_W-1:0]   people,
  input  logic                          enable,
  input  logic [lwsp_pkg::LOAD_W-1:0]   random_value,
  input  lwsp_pkg::lwsp_cmd_t           cmd,
  output lwsp_pkg::lwsp_status_t        st,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          found,
  output logic [lwsp_pkg::IDX_W-1:0]    chosen_index
);
  import lwsp_pkg::*;

  logic [LOAD_W-1:0] max_people;
  logic [1:0]        req_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LOAD_W-1:0] people_q;
  logic              enable_q;
  logic [LOAD_W-1:0] rand_q;

  logic [LOAD_W-1:0] server_load   [NUM_SERVERS];
  logic              server_enable [NUM_SERVERS];
  logic [W_W-1:0]    weight        [NUM_SERVERS];
  logic [W_W-1:0]    range_end     [NUM_SERVERS];

  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  sum;
  logic [W_W-1:0]    acc;
  logic [PROD_W-1:0] prod;
  logic [W_W-1:0]    r;
  logic [LOAD_W-1:0] rquo;
  logic              res_found;
  logic [IDX_W-1:0]  res_index;

  logic [LOAD_W-1:0] mul_op;
  logic [DEN_W-1:0]  div_divisor;
  logic [PROD_W-1:0] div_quo;
  logic              div_last;
  logic [W_W-1:0]    raw_w;
  logic [W_W-1:0]    norm_w;
  logic [W_W-1:0]    acc_next;
  logic [W_W-1:0]    hi;
  logic [W_W-1:0]    wv;
  logic              idx_ok;
  logic              raw_zero;
  logic [LOAD_W+MOD_M_W-1:0] rprod;
  logic [LOAD_W-1:0] rmod;

  assign idx_ok   = 32'(idx_q) < NUM_SERVERS;
  assign raw_zero = !server_enable[cnt] || (max_people == '0) ||
                    (server_load[cnt] > max_people);
  assign raw_w    = raw_zero ? '0 : div_quo[W_W-1:0];
  assign norm_w   = (sum == '0) ? '0 : div_quo[W_W-1:0];
  assign acc_next = acc + norm_w;
  assign hi       = range_end[cnt];
  assign wv       = weight[cnt];

  // random value modulo SCALE: reciprocal quotient, then subtract
  assign rprod = (LOAD_W+MOD_M_W)'(rand_q) * (LOAD_W+MOD_M_W)'(MOD_M);
  assign rmod  = rand_q - LOAD_W'(32'(rquo) * SCALE);

  assign mul_op = (cmd.mul_sel == MUL_HEADROOM) ? (max_people - server_load[cnt])
                                                : LOAD_W'(wv);

  always_comb begin
    case (cmd.div_den)
      DVS_MAX: div_divisor = DEN_W'(max_people);
      default: div_divisor = DEN_W'(sum);
    endcase
  end

  lwsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .step      (cmd.div_step),
    .dividend  (prod),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .last      (div_last)
  );

  assign st.req      = lwsp_req_t'(req_q);
  assign st.raw_zero = raw_zero;
  assign st.sum_zero = sum == '0;
  assign st.cnt_last = cnt == CNT_W'(NUM_SERVERS - 1);
  assign st.div_last = div_last;
  assign st.match    = (hi >= wv) && (r >= hi - wv) && (r < hi);
  assign st.out_free = !out_valid || out_ready;

  // stored state and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      max_people <= MAX_PEOPLE_RST;
      out_valid  <= 1'b0;
      cnt        <= '0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        server_load[i]   <= '0;
        server_enable[i] <= 1'b0;
        weight[i]        <= '0;
        range_end[i]     <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_people <= cfg_wdata;
      end
      if (cmd.write_entry && idx_ok) begin
        server_load[CNT_W'(idx_q)]   <= people_q;
        server_enable[CNT_W'(idx_q)] <= enable_q;
      end
      if (cmd.store_raw) begin
        weight[cnt] <= raw_w;
      end
      if (cmd.store_norm) begin
        weight[cnt]    <= norm_w;
        range_end[cnt] <= acc_next;
      end
      if (cmd.cnt_clr || cmd.clear_walk) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req_type;
      idx_q     <= server_index;
      people_q  <= people;
      enable_q  <= enable;
      rand_q    <= random_value;
      res_found <= 1'b0;
      res_index <= '0;
    end else if (cmd.pick_test && st.match) begin
      res_found <= 1'b1;
      res_index <= IDX_W'(cnt);
    end
    if (cmd.clear_walk) begin
      sum <= '0;
      acc <= '0;
    end else begin
      if (cmd.store_raw) begin
        sum <= sum + SUM_W'(raw_w);
      end
      if (cmd.store_norm) begin
        acc <= acc_next;
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mul_op) * PROD_W'(SCALE);
    end
    if (cmd.mod_quo) begin
      rquo <= LOAD_W'(rprod >> MOD_SH);
    end
    if (cmd.save_rem) begin
      r <= W_W'(rmod);
    end
    if (cmd.out_load) begin
      found        <= res_found;
      chosen_index <= res_index;
    end
  end

endmodule

[src/lwsp_ctrl.sv]
// request sequencer: dispatch, two weight passes, pick scan, result hand-off
// depends on lwsp_pkg
module lwsp_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lwsp_pkg::lwsp_status_t  st,
  output lwsp_pkg::lwsp_cmd_t     cmd
);
  import lwsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_MUL,
    S_A_DIV0,
    S_A_DIV,
    S_A_STORE,
    S_B_MUL,
    S_B_DIV0,
    S_B_DIV,
    S_B_STORE,
    S_P_QUO,
    S_P_REM,
    S_P_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.req)
          REQ_UPDATE: begin
            cmd.write_entry = 1'b1;
            state_next      = S_FINISH;
          end
          REQ_RECOMPUTE: begin
            cmd.clear_walk = 1'b1;
            state_next     = S_A_MUL;
          end
          REQ_PICK: begin
            state_next = S_P_QUO;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_A_MUL: begin
        if (st.raw_zero) begin
          cmd.store_raw = 1'b1;
          if (st.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_B_MUL;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end else begin
          cmd.mul     = 1'b1;
          cmd.mul_sel = MUL_HEADROOM;
          state_next  = S_A_DIV0;
        end
      end
      S_A_DIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_den   = DVS_MAX;
        state_next    = S_A_DIV;
      end
      S_A_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_A_STORE;
        end
      end
      S_A_STORE: begin
        cmd.store_raw = 1'b1;
        if (st.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_B_MUL;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_A_MUL;
        end
      end
      S_B_MUL: begin
        if (st.sum_zero) begin
          cmd.store_norm = 1'b1;
          if (st.cnt_last) begin
            state_next = S_FINISH;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end else begin
          cmd.mul     = 1'b1;
          cmd.mul_sel = MUL_WEIGHT;
          state_next  = S_B_DIV0;
        end
      end
      S_B_DIV0: begin
        cmd.div_start = 1'b1;
        cmd.div_den   = DVS_SUM;
        state_next    = S_B_DIV;
      end
      S_B_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_B_STORE;
        end
      end
      S_B_STORE: begin
        cmd.store_norm = 1'b1;
        if (st.cnt_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_B_MUL;
        end
      end
      S_P_QUO: begin
        cmd.mod_quo = 1'b1;
        state_next  = S_P_REM;
      end
      S_P_REM: begin
        cmd.save_rem = 1'b1;
        cmd.cnt_clr  = 1'b1;
        state_next   = S_P_SCAN;
      end
      S_P_SCAN: begin
        cmd.pick_test = 1'b1;
        if (st.match || st.cnt_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an untaken beat");

  a_walk_no_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !st.cnt_last)
    else $error("server counter wrapped during a walk");

  a_scan_on_pick: assert property (@(posedge clk) disable iff (rst)
    cmd.pick_test |-> st.req == REQ_PICK)
    else $error("range scan outside a pick request");

  a_norm_on_recompute: assert property (@(posedge clk) disable iff (rst)
    (cmd.store_norm || cmd.store_raw) |-> st.req == REQ_RECOMPUTE)
    else $error("weight write outside a recompute request");

endmodule

[src/load_weighted_server_picker_top.sv]
// load weighted server picker: one request beat in, one result beat out, one request at a time
// update writes one table entry; pick takes a reciprocal modulo, then one range compare per
// server; recompute makes two passes over all servers, each server using the
// 1-bit-per-cycle divider where it needs it; in_ready rises together with out_valid
// rst (synchronous): max_people 1000, all loads, enables, weights and range ends zero
module load_weighted_server_picker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lwsp_pkg::LOAD_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [lwsp_pkg::IDX_W-1:0]    server_index,
  input  logic [lwsp_pkg::LOAD_W-1:0]   people,
  input  logic                          enable,
  input  logic [lwsp_pkg::LOAD_W-1:0]   random_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [lwsp_pkg::IDX_W-1:0]    chosen_index
);
  import lwsp_pkg::*;

  lwsp_cmd_t    cmd;
  lwsp_status_t st;

  lwsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lwsp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_type     (req_type),
    .server_index (server_index),
    .people       (people),
    .enable       (enable),
    .random_value (random_value),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .found        (found),
    .chosen_index (chosen_index)
  );

endmodule
